// ===== rtl/container_extent_locator_defines.svh =====
// ----------------------------------------------------------------------------
// Container extent locator assertion macros
// Assertion helpers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef CONTAINER_EXTENT_LOCATOR_DEFINES_SVH
`define CONTAINER_EXTENT_LOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define CEL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define CEL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CEL_ASSERT(lbl, clk, rst_n, prop, msg)
`define CEL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/cel_pkg.sv =====
// ----------------------------------------------------------------------------
// Container extent locator package
// Shared types and codes.
// ----------------------------------------------------------------------------
`default_nettype none
package cel_pkg;
  localparam logic [1:0] CMD_ADD = 2'd0;
  localparam logic [1:0] CMD_FINALIZE = 2'd1;
  localparam logic [1:0] CMD_LOCATE = 2'd2;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_EMPTY = 3'd1;
  localparam logic [2:0] ST_PHASE = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_RANGE = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE, S_NAMES, S_CHECK, S_LAYOUT, S_SEAL, S_LOCATE, S_DONE
  } state_t;

  // Token that travels down the cell chain, one cell per cycle.
  typedef struct packed {
    logic        valid;
    logic        is_fin;
    logic [63:0] acc;      // running data sum for layout
    logic        ovf;
    logic [63:0] dpos;     // data offset being located
    logic        hit;
    logic [7:0]  hit_idx;
    logic [63:0] hit_pos;
    logic [63:0] hit_run;
  } tok_t;

  typedef struct packed {
    logic [63:0] entry_size;
    logic [7:0]  name_length;
  } add_t;
endpackage
`default_nettype wire

// ===== rtl/cel_if.sv =====
// ----------------------------------------------------------------------------
// Container extent locator channels
// Valid/ready request channels for input and result.
// ----------------------------------------------------------------------------
`default_nettype none
interface cel_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [63:0] entry_size;
  logic [7:0]  name_length;
  logic [63:0] offset;
  modport source(output valid, cmd, entry_size, name_length, offset, input ready);
  modport sink(input valid, cmd, entry_size, name_length, offset, output ready);
endinterface

interface cel_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        hdr_hit;
  logic [4:0]  entry_num;
  logic [63:0] position;
  logic [63:0] run_length;
  logic [31:0] header_bytes;
  logic [63:0] total_bytes;
  modport source(output valid, status, hdr_hit, entry_num, position, run_length,
                 header_bytes, total_bytes, input ready);
  modport sink(input valid, status, hdr_hit, entry_num, position, run_length,
               header_bytes, total_bytes, output ready);
endinterface
`default_nettype wire

// ===== rtl/cel_cell.sv =====
// ----------------------------------------------------------------------------
// Container extent locator cell
// Holds one table entry; lays it out or tests it as the token passes.
// ----------------------------------------------------------------------------
`default_nettype none
module cel_cell #(
  parameter int IDX = 0
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           wr_en,
  input  wire cel_pkg::add_t  wr_data,
  input  wire logic           active,   // entry lies below the entry count
  input  wire cel_pkg::tok_t  tok_in,
  output cel_pkg::tok_t       tok_out,
  output logic [7:0]          name_len
);
  import cel_pkg::*;
  logic [63:0] size_r, start_r;
  logic [7:0]  nlen_r;
  tok_t        tok_r, tok_nxt;
  logic [63:0] rel;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      size_r <= wr_data.entry_size;
      nlen_r <= wr_data.name_length;
    end
    if (tok_in.valid && tok_in.is_fin && active) start_r <= tok_in.acc;
  end

  always_comb begin
    tok_nxt = tok_in;
    rel = tok_in.dpos - start_r;
    if (active) begin
      if (tok_in.is_fin) begin
        if (size_r > ~tok_in.acc) tok_nxt.ovf = 1'b1;
        tok_nxt.acc = tok_in.acc + size_r;
      end else if (!tok_in.hit && tok_in.dpos >= start_r && rel < size_r) begin
        tok_nxt.hit = 1'b1;
        tok_nxt.hit_idx = 8'(IDX);
        tok_nxt.hit_pos = rel;
        tok_nxt.hit_run = size_r - rel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) tok_r.valid <= 1'b0;
    else tok_r.valid <= tok_in.valid;
    tok_r.is_fin <= tok_nxt.is_fin;
    tok_r.acc <= tok_nxt.acc;
    tok_r.ovf <= tok_nxt.ovf;
    tok_r.dpos <= tok_nxt.dpos;
    tok_r.hit <= tok_nxt.hit;
    tok_r.hit_idx <= tok_nxt.hit_idx;
    tok_r.hit_pos <= tok_nxt.hit_pos;
    tok_r.hit_run <= tok_nxt.hit_run;
  end

  assign tok_out = tok_r;
  assign name_len = nlen_r;
endmodule
`default_nettype wire

// ===== rtl/container_extent_locator.sv =====
// ----------------------------------------------------------------------------
// Container extent locator: add, errors and header locates answer straight from
// the request; entry locates pass a token through the cell chain; finalize walks
// the names, checks capacity, then sends the layout token through the chain. One request at a
// time. Synchronous active-low reset empties the table, unseals it, capacity 16384.
// ----------------------------------------------------------------------------
`default_nettype none
module container_extent_locator #(
  parameter int MAX_ENTRIES       = 32,
  parameter int MAX_NAME_LEN      = 256,
  parameter int BASE_HEADER_BYTES = 16,
  parameter int RECORD_BYTES      = 24
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  cel_in_if.sink           in_ch,
  cel_out_if.source        out_ch,
  input  wire logic        cfg_we,
  input  wire logic [31:0] cfg_wdata
);
  import cel_pkg::*;
`include "container_extent_locator_defines.svh"
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  state_t      state_r, state_nxt;
  logic [31:0] cap_r;
  logic [CW-1:0] count_r, count_nxt;
  logic        sealed_r, sealed_nxt;
  logic [31:0] hdr_r, hdr_nxt;
  logic [63:0] total_r, total_nxt;
  logic [1:0]  cmd_r;
  logic [63:0] off_r;
  logic [CW-1:0] walk_r, walk_nxt;
  logic [63:0] sum_r, sum_nxt;   // header size accumulator
  logic        ovalid_r, ovalid_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic        oinh_r, oinh_nxt;
  logic [4:0]  oidx_r, oidx_nxt;
  logic [63:0] opos_r, opos_nxt, orun_r, orun_nxt;

  tok_t tok [MAX_ENTRIES+1];
  logic [7:0] nl [MAX_ENTRIES];
  logic inject;
  tok_t inj_tok;
  add_t wr;
  logic do_add;

  assign wr.entry_size = in_ch.entry_size;
  assign wr.name_length = in_ch.name_length;
  assign in_ch.ready = (state_r == S_IDLE) && !ovalid_r;

  always_comb begin
    inj_tok = '0;
    inj_tok.valid = inject;
    inj_tok.is_fin = (cmd_r == CMD_FINALIZE);
    inj_tok.dpos = off_r - 64'(hdr_r);
  end
  assign tok[0] = inj_tok;

  genvar g;
  generate
    for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
      cel_cell #(.IDX(g)) u_cell (
        .clk(clk), .rst_n(rst_n),
        .wr_en(do_add && (count_r[AW-1:0] == AW'(g))),
        .wr_data(wr),
        .active(CW'(g) < count_r),
        .tok_in(tok[g]), .tok_out(tok[g+1]), .name_len(nl[g]));
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cap_r <= 32'd16384;
      count_r <= '0;
      sealed_r <= 1'b0;
      hdr_r <= '0;
      total_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) cap_r <= cfg_wdata;
      count_r <= count_nxt;
      sealed_r <= sealed_nxt;
      hdr_r <= hdr_nxt;
      total_r <= total_nxt;
      ovalid_r <= ovalid_nxt;
    end
    walk_r <= walk_nxt;
    sum_r <= sum_nxt;
    ost_r <= ost_nxt; oinh_r <= oinh_nxt; oidx_r <= oidx_nxt;
    opos_r <= opos_nxt; orun_r <= orun_nxt;
    if (in_ch.valid && in_ch.ready) begin
      cmd_r <= in_ch.cmd;
      off_r <= in_ch.offset;
    end
  end

  always_comb begin
    state_nxt = state_r; count_nxt = count_r; sealed_nxt = sealed_r;
    hdr_nxt = hdr_r; total_nxt = total_r; walk_nxt = walk_r; sum_nxt = sum_r;
    ovalid_nxt = ovalid_r && !out_ch.ready;
    ost_nxt = ost_r; oinh_nxt = oinh_r; oidx_nxt = oidx_r;
    opos_nxt = opos_r; orun_nxt = orun_r;
    inject = 1'b0; do_add = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          oinh_nxt = 1'b0; oidx_nxt = '0; opos_nxt = '0; orun_nxt = '0;
          ost_nxt = ST_PHASE;
          state_nxt = S_DONE;
          case (in_ch.cmd)
            CMD_ADD: begin
              if (sealed_r) ost_nxt = ST_PHASE;
              else if (count_r >= CW'(MAX_ENTRIES)) ost_nxt = ST_TOO_LARGE;
              else if (in_ch.name_length == 8'd0 ||
                       32'(in_ch.name_length) >= 32'(MAX_NAME_LEN))
                ost_nxt = ST_TOO_LARGE;
              else begin
                ost_nxt = ST_OK; do_add = 1'b1; count_nxt = count_r + 1'b1;
              end
            end
            CMD_FINALIZE: begin
              if (sealed_r) ost_nxt = ST_OK;
              else if (count_r == '0) ost_nxt = ST_EMPTY;
              else begin
                walk_nxt = '0;
                sum_nxt = 64'(BASE_HEADER_BYTES);
                state_nxt = S_NAMES;
              end
            end
            CMD_LOCATE: begin
              if (!sealed_r) ost_nxt = ST_PHASE;
              else if (in_ch.offset >= total_r) ost_nxt = ST_RANGE;
              else if (in_ch.offset < 64'(hdr_r)) begin
                ost_nxt = ST_OK; oinh_nxt = 1'b1; opos_nxt = in_ch.offset;
                orun_nxt = 64'(hdr_r) - in_ch.offset;
              end else state_nxt = S_LOCATE;
            end
            default: ost_nxt = ST_PHASE;
          endcase
        end
      end
      S_NAMES: begin
        // One name length plus record per cycle.
        sum_nxt = sum_r + 64'(nl[walk_r[AW-1:0]]) + 64'(RECORD_BYTES + 1);
        walk_nxt = walk_r + 1'b1;
        if (walk_nxt == count_r) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (sum_r > 64'(cap_r)) begin
          ost_nxt = ST_TOO_LARGE; state_nxt = S_DONE;
        end else begin
          inject = 1'b1; state_nxt = S_SEAL;
        end
      end
      S_LOCATE: begin
        inject = 1'b1; state_nxt = S_LAYOUT;
      end
      S_SEAL, S_LAYOUT: begin
        if (tok[MAX_ENTRIES].valid) begin
          state_nxt = S_DONE;
          if (state_r == S_SEAL) begin
            if (tok[MAX_ENTRIES].ovf || tok[MAX_ENTRIES].acc > ~sum_r)
              ost_nxt = ST_OVERFLOW;
            else begin
              ost_nxt = ST_OK; sealed_nxt = 1'b1;
              hdr_nxt = sum_r[31:0];
              total_nxt = sum_r + tok[MAX_ENTRIES].acc;
            end
          end else if (tok[MAX_ENTRIES].hit) begin
            ost_nxt = ST_OK;
            oidx_nxt = tok[MAX_ENTRIES].hit_idx[4:0];
            opos_nxt = tok[MAX_ENTRIES].hit_pos;
            orun_nxt = tok[MAX_ENTRIES].hit_run;
          end else ost_nxt = ST_RANGE;
        end
      end
      S_DONE: begin
        ovalid_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_ch.valid = ovalid_r;
  assign out_ch.status = ost_r;
  assign out_ch.hdr_hit = oinh_r;
  assign out_ch.entry_num = oidx_r;
  assign out_ch.position = opos_r;
  assign out_ch.run_length = orun_r;
  assign out_ch.header_bytes = hdr_r;
  assign out_ch.total_bytes = total_r;

  `CEL_ASSERT(a_cnt_max, clk, rst_n, count_r <= CW'(MAX_ENTRIES), "entry count overflow")
  `CEL_ASSERT(a_seal_cnt, clk, rst_n, sealed_r |-> count_r != '0, "sealed while empty")
  `CEL_ASSERT(a_seal_keep, clk, rst_n, $past(sealed_r) |-> sealed_r, "seal dropped")
  `CEL_ASSERT(a_no_ready_busy, clk, rst_n, (state_r != S_IDLE) |-> !in_ch.ready, "ready while busy")
endmodule
`default_nettype wire
